// ===== rtl/fcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsc_pkg
// Shared types, codes and the CRC-8 step for the frame seal/check block.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsc_pkg;

    localparam int BODY_START_DEF = 10;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SEAL_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 1'd1;

    localparam logic [7:0] SYNC_RESET = 8'hAA;
    localparam logic [7:0] CRC_POLY   = 8'h8C;

    localparam logic [2:0] ST_GOOD      = 3'd0;
    localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
    localparam logic [2:0] ST_BAD_SUM   = 3'd2;
    localparam logic [2:0] ST_BAD_CRC   = 3'd3;
    localparam logic [2:0] ST_TOO_SHORT = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       frame_last;
        logic [2:0] status;
    } t_out_beat;

    typedef struct packed {
        logic       seal_mode;
        logic [7:0] sync_value;
    } t_cfg;

    // one byte through the reflected CRC-8, LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fcsc_core.sv =====
// ----------------------------------------------------------------------------
// fcsc_core
// Frame tracking state, running CRC and checksum, and the result of each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsc_core #(
    parameter int BODY_START = fcsc_pkg::BODY_START_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  fcsc_pkg::t_in_beat     i_beat,
    input  fcsc_pkg::t_cfg         i_cfg,
    output fcsc_pkg::t_out_beat    o_res
);
    import fcsc_pkg::*;

    localparam logic [7:0] BODY_START_B = 8'(BODY_START);

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_crc, n_crc;
    logic       r_sync_good, n_sync_good;
    logic       r_in_frame, n_in_frame;

    logic [7:0] pos_inc;
    logic [7:0] outb;
    logic [7:0] sum_chk;

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        n_sum       = r_sum;
        n_crc       = r_crc;
        n_sync_good = r_sync_good;
        n_in_frame  = r_in_frame;
        pos_inc     = r_pos + 8'd1;
        sum_chk     = r_sum - i_beat.data_byte;
        outb        = i_beat.data_byte;
        o_res       = '{byte_out: i_beat.data_byte, frame_last: 1'b0, status: ST_GOOD};

        if (i_beat.frame_start) begin
            n_pos       = '0;
            n_len       = '0;
            n_in_frame  = 1'b1;
            n_sync_good = (i_beat.data_byte == i_cfg.sync_value);
            n_sum       = '0;
            n_crc       = '0;
        end else if (r_in_frame) begin
            n_pos = pos_inc;
            if (pos_inc == 8'd1) begin
                n_len = i_beat.data_byte;
                n_sum = sum_chk;
                if (i_beat.data_byte <= BODY_START_B) begin
                    o_res.frame_last = 1'b1;
                    o_res.status     = ST_TOO_SHORT;
                    n_in_frame       = 1'b0;
                end
            end else if (pos_inc == r_len) begin
                if (i_cfg.seal_mode) begin
                    outb = r_sum;
                end else begin
                    n_sum = sum_chk;
                    if (!r_sync_good) begin
                        o_res.status = ST_BAD_SYNC;
                    end else if (sum_chk != 8'd0) begin
                        o_res.status = ST_BAD_SUM;
                    end else if (r_crc != 8'd0) begin
                        o_res.status = ST_BAD_CRC;
                    end
                end
                o_res.frame_last = 1'b1;
                n_in_frame       = 1'b0;
            end else begin
                if (i_cfg.seal_mode && (pos_inc + 8'd1) == r_len) begin
                    outb = r_crc;
                end else if (pos_inc >= BODY_START_B) begin
                    n_crc = crc8_step(r_crc, i_beat.data_byte);
                end
                n_sum = r_sum - outb;
            end
        end
        o_res.byte_out = outb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_crc       <= '0;
            r_sync_good <= 1'b0;
            r_in_frame  <= 1'b0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_crc       <= n_crc;
            r_sync_good <= n_sync_good;
            r_in_frame  <= n_in_frame;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fcsc_out_reg.sv =====
// ----------------------------------------------------------------------------
// fcsc_out_reg
// Result register with valid/ready; takes a new beat when empty or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsc_out_reg (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  fcsc_pkg::t_out_beat    i_beat,
    input  wire                    i_ready,
    output logic                   o_can_load,
    output logic                   o_valid,
    output fcsc_pkg::t_out_beat    o_beat
);
    import fcsc_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_beat     = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_beat <= i_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frame_crc8_checksum_seal_check.sv =====
// ----------------------------------------------------------------------------
// frame_crc8_checksum_seal_check
// Frame seal/check: CRC-8 (reflected 0x8C) over the body, two's-complement
// checksum over bytes 1..L.
//
// Input channel (i_in_valid/o_in_ready) takes one frame byte per beat, with
// frame_start marking byte 0. Output channel (o_out_valid/i_out_ready) gives
// exactly one result beat per input beat: the byte (or inserted CRC/checksum
// in seal mode), a last flag and a status code on the last byte.
// The result is registered: it appears in the cycle after the input beat is
// accepted; one beat per cycle is sustained while the receiver is ready. The
// per-byte CRC and sum update sit between the frame state and result registers.
// When the receiver stalls, the result register holds and o_in_ready drops
// until it is taken; input ready follows output ready in the same cycle.
// Reset clears the frame state and result valid flag and loads the registers
// with check mode and sync value 0xAA. Registers must be written via i_cfg_we,
// i_cfg_idx, i_cfg_data only while no frame is in flight; this is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_crc8_checksum_seal_check #(
    parameter int BODY_START = fcsc_pkg::BODY_START_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  fcsc_pkg::t_in_beat                 i_in_beat,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output fcsc_pkg::t_out_beat                o_out_beat,
    input  wire                                i_cfg_we,
    input  wire [fcsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [fcsc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fcsc_pkg::*;

    logic      r_seal_mode;
    logic [7:0] r_sync_value;
    t_cfg      cfg;
    t_out_beat res;
    logic      can_load;
    logic      accept;

    assign cfg        = '{seal_mode: r_seal_mode, sync_value: r_sync_value};
    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seal_mode  <= 1'b0;
            r_sync_value <= SYNC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEAL_MODE:  r_seal_mode  <= i_cfg_data[0];
                CFG_SYNC_VALUE: r_sync_value <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    fcsc_core #(
        .BODY_START (BODY_START)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_in_beat),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    fcsc_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_in_valid),
        .i_beat     (res),
        .i_ready    (i_out_ready),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .o_beat     (o_out_beat)
    );

    // error codes only ever appear on the closing beat
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status != ST_GOOD |-> o_out_beat.frame_last)
        else $error("status set on a beat that does not close a frame");

    // every accepted beat yields a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted beat produced no result");

    // sealing never reports check errors
    a_seal_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seal_mode && o_out_beat.status != ST_GOOD
        |-> o_out_beat.status == ST_TOO_SHORT)
        else $error("check error reported in seal mode");

endmodule

`default_nettype wire
